[hdl/rdi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdi_pkg
// Shared types and constants for the disk image run-length decoder.
// ----------------------------------------------------------------------------
package rdi_pkg;

    localparam int POSITION_BITS_DEFAULT = 24;
    localparam int SIZE_BITS             = 24;
    localparam int CRC_BITS              = 32;
    localparam int COUNT_BITS            = 16;

    localparam logic [SIZE_BITS-1:0] IMG_LEN_RESET   = 24'd737280;
    localparam logic [CRC_BITS-1:0]  CRC_START_RESET = 32'h0000_0000;
    localparam logic [7:0]           FILL_BYTE       = 8'hF6;

    // configuration register indexes
    localparam logic REG_IMG_LEN   = 1'b0;
    localparam logic REG_CRC_START = 1'b1;

    // command kinds carried from the parser to the writer
    localparam logic [1:0] CMD_REPEAT  = 2'd0;
    localparam logic [1:0] CMD_LITERAL = 2'd1;
    localparam logic [1:0] CMD_FILL    = 2'd2;
    localparam logic [1:0] CMD_ERROR   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_FILL    = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;
    localparam logic [1:0] ST_OVERRUN = 2'd3;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            value;
        logic [COUNT_BITS-1:0] count;  // repeat length, 1..32768
        logic                  more;   // literal bytes still follow in this run
    } cmd_t;

    // reflected CRC-32 table, index cut to 6 bits
    localparam logic [31:0] CRC_TAB [64] = '{
        32'h00000000, 32'h77073096, 32'hEE0E612C, 32'h990951BA,
        32'h076DC419, 32'h706AF48F, 32'hE963A535, 32'h9E6495A3,
        32'h0EDB8832, 32'h79DCB8A4, 32'hE0D5E91E, 32'h97D2D988,
        32'h09B64C2B, 32'h7EB17CBD, 32'hE7B82D07, 32'h90BF1D91,
        32'h1DB71064, 32'h6AB020F2, 32'hF3B97148, 32'h84BE41DE,
        32'h1ADAD47D, 32'h6DDDE4EB, 32'hF4D4B551, 32'h83D385C7,
        32'h136C9856, 32'h646BA8C0, 32'hFD62F97A, 32'h8A65C9EC,
        32'h14015C4F, 32'h63066CD9, 32'hFA0F3D63, 32'h8D080DF5,
        32'h3B6E20C8, 32'h4C69105E, 32'hD56041E4, 32'hA2677172,
        32'h3C03E4D1, 32'h4B04D447, 32'hD20D85FD, 32'hA50AB56B,
        32'h35B5A8FA, 32'h42B2986C, 32'hDBBBC9D6, 32'hACBCF940,
        32'h32D86CE3, 32'h45DF5C75, 32'hDCD60DCF, 32'hABD13D59,
        32'h26D930AC, 32'h51DE003A, 32'hC8D75180, 32'hBFD06116,
        32'h21B4F4B5, 32'h56B3C423, 32'hCFBA9599, 32'hB8BDA50F,
        32'h2802B89E, 32'h5F058808, 32'hC60CD9B2, 32'hB10BE924,
        32'h2F6F7C87, 32'h58684C11, 32'hC1611DAB, 32'hB6662D3D
    };

    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [5:0] idx;
        idx = b[5:0] ^ crc[5:0];
        return CRC_TAB[idx] ^ {8'h00, crc[31:8]};
    endfunction

endpackage

[hdl/rdi_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdi_front
// Block parser: reads length headers and turns data bytes into commands.
// ----------------------------------------------------------------------------
module rdi_front
    import rdi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat,        // input beat accepted this cycle
    input  logic [7:0] stream_byte,
    input  logic       end_of_file,
    output logic       push,
    output cmd_t       push_cmd
);

    localparam logic [1:0] PH_LEN_LO  = 2'd0;
    localparam logic [1:0] PH_LEN_HI  = 2'd1;
    localparam logic [1:0] PH_REP_VAL = 2'd2;
    localparam logic [1:0] PH_LITERAL = 2'd3;

    logic [1:0]            phase_reg, phase_next;
    logic [7:0]            length_low_reg, length_low_next;
    logic [14:0]           literal_left_reg, literal_left_next;
    logic [COUNT_BITS-1:0] repeat_count_reg, repeat_count_next;
    logic [15:0]           raw_len;
    logic [14:0]           lit_dec;

    assign raw_len = {stream_byte, length_low_reg};
    assign lit_dec = literal_left_reg - 15'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        length_low_next   = length_low_reg;
        literal_left_next = literal_left_reg;
        repeat_count_next = repeat_count_reg;
        push              = 1'b0;
        push_cmd.kind     = CMD_ERROR;
        push_cmd.value    = stream_byte;
        push_cmd.count    = repeat_count_reg;
        push_cmd.more     = (lit_dec != 15'd0);
        if (beat)
        begin
            if (end_of_file)
            begin
                push          = 1'b1;
                push_cmd.kind = (phase_reg == PH_LEN_LO || phase_reg == PH_LEN_HI) ?
                                CMD_FILL : CMD_ERROR;
            end
            else
            begin
                case (phase_reg)
                    PH_LEN_LO:
                    begin
                        length_low_next = stream_byte;
                        phase_next      = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        if (raw_len == 16'd0)
                            phase_next = PH_LEN_LO;
                        else if (raw_len[15])
                        begin
                            // negative length: two's complement magnitude
                            repeat_count_next = COUNT_BITS'(17'h10000 - {1'b0, raw_len});
                            phase_next        = PH_REP_VAL;
                        end
                        else
                        begin
                            literal_left_next = raw_len[14:0];
                            phase_next        = PH_LITERAL;
                        end
                    end
                    PH_REP_VAL:
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_REPEAT;
                        phase_next    = PH_LEN_LO;
                    end
                    default:
                    begin
                        push              = 1'b1;
                        push_cmd.kind     = CMD_LITERAL;
                        literal_left_next = lit_dec;
                        if (lit_dec == 15'd0)
                            phase_next = PH_LEN_LO;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEN_LO;
            length_low_reg   <= 8'd0;
            literal_left_reg <= 15'd0;
            repeat_count_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            length_low_reg   <= length_low_next;
            literal_left_reg <= literal_left_next;
            repeat_count_reg <= repeat_count_next;
        end
    end

endmodule

[hdl/rdi_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdi_queue
// Two-entry command queue between parser and writer.
// ----------------------------------------------------------------------------
module rdi_queue
    import rdi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    cmd_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[hdl/rdi_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdi_back
// Image writer: tracks position and CRC, clamps runs, drives result register.
// ----------------------------------------------------------------------------
module rdi_back
    import rdi_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SIZE_BITS-1:0] img_len,
    input  logic                 crc_load,
    input  logic [CRC_BITS-1:0]  crc_start,
    input  logic                 q_valid,
    input  cmd_t                 q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_value,
    output logic [SIZE_BITS-1:0] out_count,
    output logic [CRC_BITS-1:0]  out_crc,
    output logic [1:0]           out_status,
    output logic                 out_last
);

    localparam int PW = POSITION_BITS;
    localparam int SW = (PW > SIZE_BITS) ? PW : SIZE_BITS;
    localparam logic [SW-1:0] PMAX = SW'((65'd1 << PW) - 65'd1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOP = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [CRC_BITS-1:0]   crc_reg, crc_next;
    logic                  finished_reg, finished_next;
    logic [7:0]            wval_reg, wval_next;
    logic [COUNT_BITS-1:0] wleft_reg, wleft_next;
    logic [COUNT_BITS-1:0] wcount_reg, wcount_next;
    logic [1:0]            wstatus_reg, wstatus_next;
    logic                  wlast_reg, wlast_next;

    logic                  ov_reg, ov_next;
    logic [7:0]            oval_reg, oval_next;
    logic [SIZE_BITS-1:0]  ocnt_reg, ocnt_next;
    logic [CRC_BITS-1:0]   ocrc_reg, ocrc_next;
    logic [1:0]            ost_reg, ost_next;
    logic                  olast_reg, olast_next;

    logic [SW-1:0]         size_w, lim_w, rem_w;
    logic [PW-1:0]         lim, rem, pos_n, pos_1;
    logic                  clamp, rep_last, slot_free, load_out;
    logic [COUNT_BITS-1:0] rep_n;
    logic [CRC_BITS-1:0]   crc_lit;

    assign size_w    = SW'(img_len);
    assign lim_w     = (size_w < PMAX) ? size_w : PMAX;
    assign lim       = lim_w[PW-1:0];
    assign rem       = (pos_reg < lim) ? (lim - pos_reg) : '0;
    assign rem_w     = SW'(rem);
    assign clamp     = (PW'(q_head.count) > rem);
    assign rep_n     = clamp ? rem[COUNT_BITS-1:0] : q_head.count;
    assign pos_n     = pos_reg + PW'(rep_n);
    assign rep_last  = clamp || (pos_n >= lim);
    assign pos_1     = pos_reg + PW'(1);
    assign crc_lit   = crc_step(crc_reg, q_head.value);
    assign slot_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        finished_next = finished_reg;
        wval_next     = wval_reg;
        wleft_next    = wleft_reg;
        wcount_next   = wcount_reg;
        wstatus_next  = wstatus_reg;
        wlast_next    = wlast_reg;
        ov_next       = ov_reg && !out_ready;
        oval_next     = oval_reg;
        ocnt_next     = ocnt_reg;
        ocrc_next     = ocrc_reg;
        ost_next      = ost_reg;
        olast_next    = olast_reg;
        q_pop         = 1'b0;
        load_out      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && finished_reg)
                    q_pop = 1'b1;  // decoding stopped: drop
                else if (q_valid && q_head.kind == CMD_REPEAT && rep_n != '0)
                begin
                    q_pop        = 1'b1;
                    wval_next    = q_head.value;
                    wleft_next   = rep_n;
                    wcount_next  = rep_n;
                    wstatus_next = clamp ? ST_OVERRUN : ST_DATA;
                    wlast_next   = rep_last;
                    pos_next     = pos_n;
                    state_next   = S_LOOP;
                end
                else if (q_valid && slot_free)
                begin
                    q_pop     = 1'b1;
                    load_out  = 1'b1;
                    oval_next = q_head.value;
                    ocnt_next = '0;
                    ocrc_next = crc_reg;
                    case (q_head.kind)
                        CMD_REPEAT:
                        begin
                            // nothing left to write for this run
                            ost_next   = clamp ? ST_OVERRUN : ST_DATA;
                            olast_next = rep_last;
                        end
                        CMD_LITERAL:
                        begin
                            if (rem == '0)
                            begin
                                ost_next   = ST_OVERRUN;
                                olast_next = 1'b1;
                            end
                            else
                            begin
                                crc_next   = crc_lit;
                                pos_next   = pos_1;
                                ocrc_next  = crc_lit;
                                ocnt_next  = SIZE_BITS'(1);
                                olast_next = (pos_1 >= lim);
                                ost_next   = ((pos_1 >= lim) && q_head.more) ?
                                             ST_OVERRUN : ST_DATA;
                            end
                        end
                        CMD_FILL:
                        begin
                            oval_next  = FILL_BYTE;
                            ocnt_next  = rem_w[SIZE_BITS-1:0];
                            pos_next   = pos_reg + rem;
                            ost_next   = ST_FILL;
                            olast_next = 1'b1;
                        end
                        default:
                        begin
                            oval_next  = 8'd0;
                            ost_next   = ST_TRUNC;
                            olast_next = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOP:
            begin
                crc_next   = crc_step(crc_reg, wval_reg);
                wleft_next = wleft_reg - COUNT_BITS'(1);
                if (wleft_reg == COUNT_BITS'(1))
                    state_next = S_EMIT;
            end
            default:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    oval_next  = wval_reg;
                    ocnt_next  = SIZE_BITS'(wcount_reg);
                    ocrc_next  = crc_reg;
                    ost_next   = wstatus_reg;
                    olast_next = wlast_reg;
                    state_next = S_IDLE;
                end
            end
        endcase

        if (load_out)
        begin
            ov_next = 1'b1;
            if (olast_next)
                finished_next = 1'b1;
        end

        if (crc_load)
            crc_next = crc_start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            crc_reg      <= CRC_START_RESET;
            finished_reg <= 1'b0;
            ov_reg       <= 1'b0;
            wleft_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            finished_reg <= finished_next;
            ov_reg       <= ov_next;
            wleft_reg    <= wleft_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wval_reg    <= wval_next;
        wcount_reg  <= wcount_next;
        wstatus_reg <= wstatus_next;
        wlast_reg   <= wlast_next;
        oval_reg    <= oval_next;
        ocnt_reg    <= ocnt_next;
        ocrc_reg    <= ocrc_next;
        ost_reg     <= ost_next;
        olast_reg   <= olast_next;
    end

    assign out_valid  = ov_reg;
    assign out_value  = oval_reg;
    assign out_count  = ocnt_reg;
    assign out_crc    = ocrc_reg;
    assign out_status = ost_reg;
    assign out_last   = olast_reg;

    // no result is produced once the image is closed
    a_no_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !finished_reg)
        else $error("result loaded after decoding finished");

    // a final result closes the image on the next edge
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && olast_next) |=> finished_reg)
        else $error("final result did not close the image");

    // the repeat loop never runs with an empty count
    a_loop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOP) |-> (wleft_reg != '0))
        else $error("repeat loop running with zero count");

    // a run in progress never starts after the image closed
    a_busy_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !finished_reg)
        else $error("run in progress after decoding finished");

endmodule

[hdl/rle_disk_image_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_disk_image_decoder_unit
// Run-length decoder for a compressed floppy image stream with running CRC.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  -------  ---  -------------------------------------------------------------
//  s_*      in   one compressed byte, or the end-of-file marker
//  m_*      out  one run: value, count, CRC after the run, status, last
//  cfg_*    in   register write: 0 image length, 1 crc_start (also loads CRC)
//
//  Header and literal bytes: one beat per cycle on the input side while the queue has room.
//  A repeat run occupies the writer for one CRC table step per
//  repeated byte; the two-entry command queue lets the parser run ahead.
//  Reset brings the parser to a block boundary, position 0 and CRC 0;
//  no clearing pass. A stalled m_tready backs up the writer, then the queue,
//  then s_tready. Once a result with last goes out, later beats are dropped.
// ----------------------------------------------------------------------------
module rle_disk_image_decoder_unit
    import rdi_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    input  logic        s_tuser,   // [0] end_of_file
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] run_value, [31:8] run_count, [63:32] running_crc
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,   // last
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic                 s_beat;
    logic                 push, q_full, q_valid, q_pop;
    cmd_t                 push_cmd, q_head;
    logic                 cfg_beat, crc_load;
    logic [SIZE_BITS-1:0] img_len_reg, img_len_next;
    logic [7:0]           run_value;
    logic [SIZE_BITS-1:0] run_count;
    logic [CRC_BITS-1:0]  running_crc;

    // the user issues config writes only while idle; the block does not enforce it, so always accept
    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign crc_load  = cfg_beat && (cfg_index == REG_CRC_START);

    always_comb
    begin
        img_len_next = img_len_reg;
        if (cfg_beat && cfg_index == REG_IMG_LEN)
            img_len_next = cfg_data[SIZE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            img_len_reg <= IMG_LEN_RESET;
        else
            img_len_reg <= img_len_next;
    end

    // parser accepts whenever the queue has room
    assign s_tready = !q_full;
    assign s_beat   = s_tvalid && s_tready;

    rdi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (s_beat),
        .stream_byte (s_tdata),
        .end_of_file (s_tuser),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    rdi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    rdi_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .img_len    (img_len_reg),
        .crc_load   (crc_load),
        .crc_start  (cfg_data),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (run_value),
        .out_count  (run_count),
        .out_crc    (running_crc),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {running_crc, run_count, run_value};

endmodule
